@@ design/tap_tempo_beat_tracker_core_assert.svh @@
// ----------------------------------------------------------------------------
// Tap tempo beat tracker: assertion macros
// Shared concurrent check forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef TAP_TEMPO_BEAT_TRACKER_CORE_ASSERT_SVH
`define TAP_TEMPO_BEAT_TRACKER_CORE_ASSERT_SVH

// same-cycle implication
`define TTBT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TTBT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/ttbt_pkg.sv @@
// ----------------------------------------------------------------------------
// ttbt_pkg
// Shared constants, micro-op codes and interface structs of the beat tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ttbt_pkg;

	localparam int WINDOW     = 8;
	localparam int FRAC_BITS  = 16;
	localparam int TIME_W     = 32 + FRAC_BITS;
	localparam int HEAD_W     = $clog2(WINDOW);
	localparam int CNT_W      = $clog2(WINDOW + 1);
	localparam int DVD_W      = TIME_W;
	localparam int DVS_W      = 32;
	localparam int DCNT_W     = $clog2(DVD_W + 1);
	localparam int BPM_W      = 27;
	localparam int PC_W       = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [15:0]       TIMEOUT_RST  = 16'd2000;
	localparam logic [3:0]        WINDOW_RST   = 4'd8;
	localparam logic [31:0]       PERIOD_RST   = 32'(64'd1000 << FRAC_BITS);
	localparam logic [BPM_W-1:0]  BPM_RST      = BPM_W'(60 << 8);
	localparam logic [BPM_W-1:0]  BPM_MAX      = '1;
	localparam logic [DVD_W-1:0]  BPM_DIVIDEND = DVD_W'(64'd60000 << (8 + FRAC_BITS));

	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 1'b1;

	typedef enum logic [4:0] {
		UOP_NOP,
		UOP_RD_NEWEST,
		UOP_TAP_GAP,
		UOP_TAP_WRITE,
		UOP_SET_N,
		UOP_RD_OLDEST,
		UOP_DIV_PERIOD,
		UOP_SET_PERIOD,
		UOP_DIV_BPM,
		UOP_SET_BPM,
		UOP_BPM_SAT,
		UOP_FRAME_ANCHOR,
		UOP_FRAME_DIFF,
		UOP_DIV_K,
		UOP_FRAME_STEP,
		UOP_DIV_FRAC,
		UOP_SET_FRAC,
		UOP_FRAC_ZERO,
		UOP_EMIT
	} uop_t;

	typedef enum logic [2:0] {
		COND_NEXT,
		COND_ALWAYS,
		COND_IS_FRAME,
		COND_CNT_LT2,
		COND_PERIOD_ZERO,
		COND_DIFF_NONPOS,
		COND_DIV_BUSY,
		COND_OUT_BLOCKED
	} cond_t;

	typedef enum logic {
		SQ_IDLE,
		SQ_RUN
	} seq_state_t;

	typedef struct packed {
		uop_t            uop;
		cond_t           cond;
		logic            last;
		logic [PC_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic is_frame;
		logic cnt_lt2;
		logic period_zero;
		logic diff_nonpos;
		logic div_busy;
		logic out_blocked;
	} status_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic [DVD_W-1:0] quot;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic                 beat_pulse;
		logic [BPM_W-1:0]     bpm_q8;
		logic                 bpm_updated;
		logic                 period_zero;
		logic [31:0]          sync_beats;
		logic [FRAC_BITS-1:0] sync_fraction;
		logic                 sync_updated;
	} result_t;

endpackage

`default_nettype wire

@@ design/ttbt_div.sv @@
// ----------------------------------------------------------------------------
// ttbt_div
// Restoring serial divider, one quotient bit per cycle, with remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module ttbt_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ttbt_pkg::div_req_t req,
	output ttbt_pkg::div_rsp_t rsp
);
	import ttbt_pkg::*;

	logic              busy_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;

	logic [DVS_W:0] trial;
	logic [DVS_W:0] trial_sub;
	logic           fits;

	// partial remainder stays below the divisor, so one extra bit is enough
	assign trial     = {rem_q, quo_q[DVD_W-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign fits      = ~trial_sub[DVS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= DCNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - DCNT_W'(1);
			if (cnt_q == DCNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

@@ design/ttbt_useq.sv @@
// ----------------------------------------------------------------------------
// ttbt_useq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module ttbt_useq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ttbt_pkg::status_t status,
	output logic              idle,
	output ttbt_pkg::uop_t    uop
);
	import ttbt_pkg::*;

	localparam logic [PC_W-1:0] PC_NONE      = '0;
	localparam logic [PC_W-1:0] PC_WAIT_P    = 5'd7;
	localparam logic [PC_W-1:0] PC_WAIT_B    = 5'd11;
	localparam logic [PC_W-1:0] PC_BPM_SAT   = 5'd13;
	localparam logic [PC_W-1:0] PC_FRAME     = 5'd14;
	localparam logic [PC_W-1:0] PC_WAIT_K    = 5'd19;
	localparam logic [PC_W-1:0] PC_WAIT_F    = 5'd22;
	localparam logic [PC_W-1:0] PC_FRAC_ZERO = 5'd24;
	localparam logic [PC_W-1:0] PC_EMIT      = 5'd25;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			// tap: gap check, record, mean interval, tempo
			5'd0:  w = '{UOP_NOP,          COND_IS_FRAME,    1'b0, PC_FRAME};
			5'd1:  w = '{UOP_RD_NEWEST,    COND_NEXT,        1'b0, PC_NONE};
			5'd2:  w = '{UOP_TAP_GAP,      COND_NEXT,        1'b0, PC_NONE};
			5'd3:  w = '{UOP_TAP_WRITE,    COND_NEXT,        1'b0, PC_NONE};
			5'd4:  w = '{UOP_SET_N,        COND_CNT_LT2,     1'b0, PC_EMIT};
			5'd5:  w = '{UOP_RD_OLDEST,    COND_NEXT,        1'b0, PC_NONE};
			5'd6:  w = '{UOP_DIV_PERIOD,   COND_NEXT,        1'b0, PC_NONE};
			5'd7:  w = '{UOP_NOP,          COND_DIV_BUSY,    1'b0, PC_WAIT_P};
			5'd8:  w = '{UOP_SET_PERIOD,   COND_NEXT,        1'b0, PC_NONE};
			5'd9:  w = '{UOP_NOP,          COND_PERIOD_ZERO, 1'b0, PC_BPM_SAT};
			5'd10: w = '{UOP_DIV_BPM,      COND_NEXT,        1'b0, PC_NONE};
			5'd11: w = '{UOP_NOP,          COND_DIV_BUSY,    1'b0, PC_WAIT_B};
			5'd12: w = '{UOP_SET_BPM,      COND_ALWAYS,      1'b0, PC_EMIT};
			5'd13: w = '{UOP_BPM_SAT,      COND_ALWAYS,      1'b0, PC_EMIT};
			// frame: anchor, elapsed whole beats, fraction
			5'd14: w = '{UOP_NOP,          COND_PERIOD_ZERO, 1'b0, PC_EMIT};
			5'd15: w = '{UOP_FRAME_ANCHOR, COND_NEXT,        1'b0, PC_NONE};
			5'd16: w = '{UOP_FRAME_DIFF,   COND_NEXT,        1'b0, PC_NONE};
			5'd17: w = '{UOP_NOP,          COND_DIFF_NONPOS, 1'b0, PC_FRAC_ZERO};
			5'd18: w = '{UOP_DIV_K,        COND_NEXT,        1'b0, PC_NONE};
			5'd19: w = '{UOP_NOP,          COND_DIV_BUSY,    1'b0, PC_WAIT_K};
			5'd20: w = '{UOP_FRAME_STEP,   COND_NEXT,        1'b0, PC_NONE};
			5'd21: w = '{UOP_DIV_FRAC,     COND_NEXT,        1'b0, PC_NONE};
			5'd22: w = '{UOP_NOP,          COND_DIV_BUSY,    1'b0, PC_WAIT_F};
			5'd23: w = '{UOP_SET_FRAC,     COND_ALWAYS,      1'b0, PC_EMIT};
			5'd24: w = '{UOP_FRAC_ZERO,    COND_NEXT,        1'b0, PC_NONE};
			// hold the result until the output register frees up
			5'd25: w = '{UOP_EMIT,         COND_OUT_BLOCKED, 1'b1, PC_EMIT};
			default: w = '{UOP_NOP,        COND_ALWAYS,      1'b0, PC_EMIT};
		endcase
		return w;
	endfunction

	seq_state_t      state_q, state_n;
	logic [PC_W-1:0] pc_q, pc_n;
	uword_t          word;
	logic            jump;

	assign word = ucode(pc_q);

	always_comb begin
		case (word.cond)
			COND_NEXT:        jump = 1'b0;
			COND_ALWAYS:      jump = 1'b1;
			COND_IS_FRAME:    jump = status.is_frame;
			COND_CNT_LT2:     jump = status.cnt_lt2;
			COND_PERIOD_ZERO: jump = status.period_zero;
			COND_DIFF_NONPOS: jump = status.diff_nonpos;
			COND_DIV_BUSY:    jump = status.div_busy;
			COND_OUT_BLOCKED: jump = status.out_blocked;
			default:          jump = 1'b0;
		endcase
	end

	always_comb begin
		state_n = state_q;
		pc_n    = pc_q;
		case (state_q)
			SQ_IDLE: begin
				if (start) begin
					state_n = SQ_RUN;
					pc_n    = '0;
				end
			end
			SQ_RUN: begin
				if (jump) begin
					pc_n = word.target;
				end else if (word.last) begin
					state_n = SQ_IDLE;
					pc_n    = '0;
				end else begin
					pc_n = pc_q + PC_W'(1);
				end
			end
			default: begin
				state_n = SQ_IDLE;
				pc_n    = '0;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			SQ_RUN: begin
				idle = 1'b0;
				uop  = word.uop;
			end
			default: begin
				idle = 1'b1;
				uop  = UOP_NOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_n;
			pc_q    <= pc_n;
		end
	end

endmodule

`default_nettype wire

@@ design/ttbt_dp.sv @@
// ----------------------------------------------------------------------------
// ttbt_dp
// Datapath: tap history memory, tempo and phase state, divider operand muxing.
// ----------------------------------------------------------------------------
`default_nettype none

module ttbt_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_take,
	input  logic                                command,
	input  logic [31:0]                         time_ms,
	input  logic                                cfg_we,
	input  logic [ttbt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ttbt_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  ttbt_pkg::uop_t                      uop,
	input  logic                                out_blocked,
	input  ttbt_pkg::div_rsp_t                  div_rsp,
	output ttbt_pkg::div_req_t                  div_req,
	output ttbt_pkg::status_t                   status,
	output ttbt_pkg::result_t                   result
);
	import ttbt_pkg::*;

	localparam int X_W = CNT_W + 1;

	logic [31:0] tap_mem [WINDOW];
	logic [31:0] rd_q;

	logic                 cmd_q;
	logic [31:0]          t_q;
	logic [15:0]          timeout_q;
	logic [3:0]           window_q;
	logic [HEAD_W-1:0]    head_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     n_q;
	logic [31:0]          period_q;
	logic [BPM_W-1:0]     tempo_q;
	logic [TIME_W-1:0]    lbt_q;
	logic                 started_q;
	logic [31:0]          beats_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [TIME_W-1:0]    diff_q;
	logic [31:0]          r_q;
	logic                 pulse_q;
	logic                 bupd_q;
	logic                 supd_q;

	logic [TIME_W-1:0] now;
	logic [31:0]       t_diff;
	logic              gap_clear;
	logic [HEAD_W-1:0] newest_idx;
	logic [HEAD_W-1:0] oldest_idx;
	logic [HEAD_W-1:0] head_inc;
	logic [HEAD_W-1:0] rd_idx;
	logic [X_W-1:0]    head_x;
	logic [X_W-1:0]    n_x;
	logic [X_W-1:0]    oldest_x;
	logic [CNT_W-1:0]  win_sel;
	logic [31:0]       r_next;

	assign now    = {t_q, {FRAC_BITS{1'b0}}};
	assign t_diff = t_q - rd_q;

	// history clears once the gap reaches the timeout
	assign gap_clear = (count_q != '0) && (t_diff >= {16'd0, timeout_q});

	assign newest_idx = (head_q == '0) ? HEAD_W'(WINDOW - 1) : head_q - HEAD_W'(1);
	assign head_inc   = (head_q == HEAD_W'(WINDOW - 1)) ? '0 : head_q + HEAD_W'(1);

	// oldest of the n newest entries sits n places behind the write pointer
	assign head_x     = X_W'(head_q);
	assign n_x        = X_W'(n_q);
	assign oldest_x   = (head_x >= n_x) ? head_x - n_x : head_x + X_W'(WINDOW) - n_x;
	assign oldest_idx = oldest_x[HEAD_W-1:0];

	assign rd_idx = (uop == UOP_RD_OLDEST) ? oldest_idx : newest_idx;

	always_comb begin
		if (window_q < 4'd2) begin
			win_sel = CNT_W'(2);
		end else if (32'(window_q) > 32'(WINDOW)) begin
			win_sel = CNT_W'(WINDOW);
		end else begin
			win_sel = CNT_W'(window_q);
		end
	end

	// divider ran on diff-1, so the true remainder is one more
	assign r_next = div_rsp.rem + 32'd1;

	always_ff @(posedge clk) begin
		if (uop == UOP_TAP_WRITE) begin
			tap_mem[head_q] <= t_q;
		end
		if (uop == UOP_RD_NEWEST || uop == UOP_RD_OLDEST) begin
			rd_q <= tap_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q <= command;
			t_q   <= time_ms;
		end
		case (uop)
			UOP_SET_N:      n_q    <= (win_sel > count_q) ? count_q : win_sel;
			UOP_FRAME_DIFF: diff_q <= now - lbt_q;
			UOP_FRAME_STEP: r_q    <= r_next;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			window_q  <= WINDOW_RST;
			head_q    <= '0;
			count_q   <= '0;
			period_q  <= PERIOD_RST;
			tempo_q   <= BPM_RST;
			lbt_q     <= '0;
			started_q <= 1'b0;
			beats_q   <= '0;
			frac_q    <= '0;
			pulse_q   <= 1'b0;
			bupd_q    <= 1'b0;
			supd_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TIMEOUT: timeout_q <= cfg_data[15:0];
					CFG_WINDOW:  window_q  <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (in_take) begin
				pulse_q <= 1'b0;
				bupd_q  <= 1'b0;
				supd_q  <= 1'b0;
			end
			case (uop)
				UOP_TAP_GAP: begin
					if (gap_clear) begin
						count_q <= '0;
					end
					lbt_q   <= now;
					pulse_q <= 1'b1;
				end
				UOP_TAP_WRITE: begin
					head_q <= head_inc;
					if (count_q != CNT_W'(WINDOW)) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				UOP_SET_PERIOD: begin
					period_q <= (|div_rsp.quot[DVD_W-1:32]) ? '1 : div_rsp.quot[31:0];
					bupd_q   <= 1'b1;
				end
				UOP_SET_BPM: begin
					tempo_q <= (|div_rsp.quot[DVD_W-1:BPM_W]) ? BPM_MAX
						: div_rsp.quot[BPM_W-1:0];
				end
				UOP_BPM_SAT: tempo_q <= BPM_MAX;
				UOP_FRAME_ANCHOR: begin
					supd_q <= 1'b1;
					if (!started_q) begin
						started_q <= 1'b1;
						lbt_q     <= now;
						beats_q   <= '0;
					end
				end
				UOP_FRAME_STEP: begin
					// last beat advances by k periods, i.e. to now minus remainder
					if (div_rsp.quot != '0) begin
						pulse_q <= 1'b1;
						beats_q <= beats_q + div_rsp.quot[31:0];
						lbt_q   <= now - TIME_W'(r_next);
					end
				end
				UOP_SET_FRAC: begin
					frac_q <= (|div_rsp.quot[DVD_W-1:FRAC_BITS]) ? '1
						: div_rsp.quot[FRAC_BITS-1:0];
				end
				UOP_FRAC_ZERO: frac_q <= '0;
				default: ;
			endcase
		end
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = period_q;
		case (uop)
			UOP_DIV_PERIOD: begin
				div_req.start    = 1'b1;
				div_req.dividend = {t_diff, {FRAC_BITS{1'b0}}};
				div_req.divisor  = DVS_W'(n_q - CNT_W'(1));
			end
			UOP_DIV_BPM: begin
				div_req.start    = 1'b1;
				div_req.dividend = BPM_DIVIDEND;
			end
			UOP_DIV_K: begin
				div_req.start    = 1'b1;
				div_req.dividend = diff_q - DVD_W'(1);
			end
			UOP_DIV_FRAC: begin
				div_req.start    = 1'b1;
				div_req.dividend = {r_q, {FRAC_BITS{1'b0}}};
			end
			default: ;
		endcase
	end

	always_comb begin
		status.is_frame    = cmd_q;
		status.cnt_lt2     = (count_q < CNT_W'(2));
		status.period_zero = (period_q == '0);
		status.diff_nonpos = diff_q[TIME_W-1] | (diff_q == '0);
		status.div_busy    = div_rsp.busy;
		status.out_blocked = out_blocked;
	end

	always_comb begin
		result.beat_pulse    = pulse_q;
		result.bpm_q8        = tempo_q;
		result.bpm_updated   = bupd_q;
		result.period_zero   = (period_q == '0);
		result.sync_beats    = beats_q;
		result.sync_fraction = frac_q;
		result.sync_updated  = supd_q;
	end

endmodule

`default_nettype wire

@@ design/tap_tempo_beat_tracker_core.sv @@
// ----------------------------------------------------------------------------
// Tap tempo beat tracker core: one request in flight, result held in an output register.
// Tempo taps and phase updates each run up to two passes through the serial divider.
// A new request is taken only while the sequencer is idle; a waiting result stalls the next emit.
// Async reset: timeout 2000 ms, window 8, period 1000 ms, 60 bpm; tap count reset, memory kept.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tap_tempo_beat_tracker_core_assert.svh"

module tap_tempo_beat_tracker_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 command,
	input  logic [31:0]                          time_ms,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 beat_pulse,
	output logic [ttbt_pkg::BPM_W-1:0]           bpm_q8,
	output logic                                 bpm_updated,
	output logic                                 period_zero,
	output logic [31:0]                          sync_beats,
	output logic [ttbt_pkg::FRAC_BITS-1:0]       sync_fraction,
	output logic                                 sync_updated,
	input  logic                                 cfg_we,
	input  logic [ttbt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ttbt_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ttbt_pkg::*;

	logic     seq_idle;
	logic     in_take;
	logic     out_blocked;
	logic     emit;
	uop_t     uop;
	status_t  status;
	div_req_t div_req;
	div_rsp_t div_rsp;
	result_t  result;

	logic    out_valid_q;
	result_t res_q;

	assign in_ready    = seq_idle;
	assign in_take     = in_valid & seq_idle;
	assign out_blocked = out_valid_q & ~out_ready;
	assign emit        = (uop == UOP_EMIT) & ~out_blocked;

	ttbt_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_take),
		.status (status),
		.idle   (seq_idle),
		.uop    (uop)
	);

	ttbt_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_take     (in_take),
		.command     (command),
		.time_ms     (time_ms),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.uop         (uop),
		.out_blocked (out_blocked),
		.div_rsp     (div_rsp),
		.div_req     (div_req),
		.status      (status),
		.result      (result)
	);

	ttbt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// output register: a new request may start while this one waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign beat_pulse    = res_q.beat_pulse;
	assign bpm_q8        = res_q.bpm_q8;
	assign bpm_updated   = res_q.bpm_updated;
	assign period_zero   = res_q.period_zero;
	assign sync_beats    = res_q.sync_beats;
	assign sync_fraction = res_q.sync_fraction;
	assign sync_updated  = res_q.sync_updated;

	`TTBT_ASSERT_NEXT(a_take_starts_run, in_valid && in_ready, !in_ready,
		"sequencer did not leave idle after a request was taken")
	`TTBT_ASSERT_NOW(a_div_no_restart, div_req.start, !div_rsp.busy,
		"divider restarted while a division was in progress")
	`TTBT_ASSERT_NEXT(a_emit_ends_item, emit, in_ready && out_valid,
		"result loaded but sequencer not back to idle")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench: tap tempo beat tracker core
// Sends tap events and frame ticks through the valid/ready ports. Each result
// is compared with the bench's own tempo and phase tracker, or a typed row. A
// short table of corner cases comes first. Random tapping runs follow, under
// several register settings, with random idle bursts on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import ttbt_pkg::*;

	localparam logic        CMD_TAP      = 1'b0;
	localparam logic        CMD_FRAME    = 1'b1;
	localparam int          WDOG_LIMIT   = 3000;
	localparam int          DRAIN_CYCLES = 120;
	localparam int          PHASES       = 8;
	localparam int          PHASE_REQS   = 135;
	localparam logic [63:0] TIME_MASK    = (64'd1 << TIME_W) - 1;
	localparam logic [63:0] FRAC_MAX     = (64'd1 << FRAC_BITS) - 1;

	typedef enum logic [1:0] {ROW_REQ, ROW_CHECKED, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic                  cmd;
		logic [31:0]           t;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		result_t               res;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  command;
	logic [31:0]           time_ms;
	logic                  out_valid;
	logic                  out_ready;
	logic                  beat_pulse;
	logic [BPM_W-1:0]      bpm_q8;
	logic                  bpm_updated;
	logic                  period_zero;
	logic [31:0]           sync_beats;
	logic [FRAC_BITS-1:0]  sync_fraction;
	logic                  sync_updated;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tap_tempo_beat_tracker_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.time_ms       (time_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.beat_pulse    (beat_pulse),
		.bpm_q8        (bpm_q8),
		.bpm_updated   (bpm_updated),
		.period_zero   (period_zero),
		.sync_beats    (sync_beats),
		.sync_fraction (sync_fraction),
		.sync_updated  (sync_updated),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// tracker state, starting from the reset values
	logic [31:0]          hist [WINDOW];
	int unsigned          hist_cnt = 0;
	int unsigned          hist_head = 0;
	logic [31:0]          period = PERIOD_RST;
	logic [BPM_W-1:0]     tempo = BPM_RST;
	logic [TIME_W-1:0]    anchor = '0;
	bit                   tracking = 1'b0;
	logic [31:0]          beats = '0;
	logic [FRAC_BITS-1:0] frac = '0;
	logic [15:0]          tmo_reg = TIMEOUT_RST;
	logic [3:0]           win_reg = WINDOW_RST;

	result_t              due_beat_reports [$];
	bit                   row_typed = 1'b0;
	result_t              typed_res = '0;
	int                   mismatches = 0;
	int                   stall_cycles = 0;
	int                   sent = 0;
	bit                   tx_idle = 1'b0;
	bit                   rx_idle = 1'b1;

	function automatic result_t advance_tracker(logic cmd, logic [31:0] t);
		result_t     res;
		logic [31:0] gap;
		logic [31:0] span;
		logic [63:0] per_q;
		logic [63:0] bpm;
		logic [63:0] now;
		logic [63:0] diff;
		logic [63:0] k;
		logic [63:0] r;
		logic [63:0] fr;
		int unsigned n;
		int unsigned oldest;
		res = '0;
		if (cmd == CMD_TAP) begin
			if (hist_cnt > 0) begin
				gap = t - hist[(hist_head + WINDOW - 1) % WINDOW];
				if (gap >= 32'(tmo_reg))
					hist_cnt = 0;
			end
			anchor = TIME_W'(64'(t) << FRAC_BITS);
			hist[hist_head] = t;
			hist_head = (hist_head + 1) % WINDOW;
			if (hist_cnt < WINDOW)
				hist_cnt++;
			res.beat_pulse = 1'b1;
			if (hist_cnt >= 2) begin
				n = 32'(win_reg);
				if (n < 2)
					n = 2;
				if (n > WINDOW)
					n = WINDOW;
				if (n > hist_cnt)
					n = hist_cnt;
				oldest = (hist_head + WINDOW - n) % WINDOW;
				span = t - hist[oldest];
				per_q = (64'(span) << FRAC_BITS) / 64'(n - 1);
				if (per_q > 64'hFFFF_FFFF)
					per_q = 64'hFFFF_FFFF;
				period = per_q[31:0];
				if (per_q == 0) begin
					tempo = BPM_MAX;
				end else begin
					bpm = (64'd60000 << (8 + FRAC_BITS)) / per_q;
					tempo = (bpm > 64'(BPM_MAX)) ? BPM_MAX : bpm[BPM_W-1:0];
				end
				res.bpm_updated = 1'b1;
			end
		end else if (period != 0) begin
			now = 64'(t) << FRAC_BITS;
			if (!tracking) begin
				tracking = 1'b1;
				anchor = TIME_W'(now);
				beats = '0;
			end
			diff = (now - 64'(anchor)) & TIME_MASK;
			// negative elapsed time: no beat, fraction pinned to zero
			if (diff[TIME_W-1]) begin
				frac = '0;
			end else begin
				k = (diff == 0) ? 64'd0 : (diff - 1) / 64'(period);
				r = diff - k * 64'(period);
				if (k != 0) begin
					res.beat_pulse = 1'b1;
					beats = beats + k[31:0];
					anchor = TIME_W'(64'(anchor) + k * 64'(period));
				end
				// a remainder of one full period saturates the fraction
				fr = (r << FRAC_BITS) / 64'(period);
				frac = (fr > FRAC_MAX) ? {FRAC_BITS{1'b1}} : fr[FRAC_BITS-1:0];
			end
			res.sync_updated = 1'b1;
		end
		res.bpm_q8 = tempo;
		res.period_zero = (period == 0);
		res.sync_beats = beats;
		res.sync_fraction = frac;
		return res;
	endfunction

	function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0d, actual %0d", name, want_v, got_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_beat_reports.size() == 0) begin
					$error("result with no request pending");
					mismatches++;
				end else begin
					want = due_beat_reports.pop_front();
					check_field("beat_pulse", 64'(want.beat_pulse), 64'(beat_pulse));
					check_field("bpm_q8", 64'(want.bpm_q8), 64'(bpm_q8));
					check_field("bpm_updated", 64'(want.bpm_updated), 64'(bpm_updated));
					check_field("period_zero", 64'(want.period_zero), 64'(period_zero));
					check_field("sync_beats", 64'(want.sync_beats), 64'(sync_beats));
					check_field("sync_fraction", 64'(want.sync_fraction),
						64'(sync_fraction));
					check_field("sync_updated", 64'(want.sync_updated), 64'(sync_updated));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_TIMEOUT: tmo_reg = cfg_data;
					CFG_WINDOW:  win_reg = cfg_data[3:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				want = advance_tracker(command, time_ms);
				due_beat_reports.push_back(row_typed ? typed_res : want);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WDOG_LIMIT) begin
				$error("watchdog: nothing moved for %0d cycles", WDOG_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stall bursts, ready stretches in between, some of them long
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_idle && $urandom_range(0, 3) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 5)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
				if ($urandom_range(0, 7) == 0)
					repeat ($urandom_range(50, 200)) @(negedge clk);
				else
					repeat ($urandom_range(1, 24)) @(negedge clk);
			end
		end
	end

	function automatic dir_row_t mk_row(row_kind_t kind, logic cmd, logic [31:0] t,
			result_t res);
		dir_row_t row;
		row.kind = kind;
		row.cmd = cmd;
		row.t = t;
		row.idx = CFG_TIMEOUT;
		row.data = '0;
		row.res = res;
		return row;
	endfunction

	function automatic dir_row_t mk_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		dir_row_t row;
		row = mk_row(ROW_CFG, CMD_TAP, '0, '0);
		row.idx = idx;
		row.data = data;
		return row;
	endfunction

	task automatic wait_drained();
		in_valid = 1'b0;
		while (due_beat_reports.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		wait_drained();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_req(logic cmd, logic [31:0] t, bit typed, result_t res);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid = 1'b1;
		command = cmd;
		time_ms = t;
		row_typed = typed;
		typed_res = res;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	initial begin
		dir_row_t    tab [$];
		int          pick;
		int          phase_start;
		int          ntaps;
		int          ival;
		bit          tail;
		logic [15:0] tmo;
		logic [15:0] win;
		logic [31:0] tnow;
		logic [31:0] last_tap;
		logic [31:0] ft;

		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_TAP;
		time_ms = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_TIMEOUT;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first tap, then a repeated time (zero period), then a frozen frame
		tab.push_back(mk_row(ROW_CHECKED, CMD_TAP, 32'd1000,
			result_t'{1'b1, BPM_RST, 1'b0, 1'b0, 32'd0, 16'd0, 1'b0}));
		tab.push_back(mk_row(ROW_CHECKED, CMD_TAP, 32'd1000,
			result_t'{1'b1, BPM_MAX, 1'b1, 1'b1, 32'd0, 16'd0, 1'b0}));
		tab.push_back(mk_row(ROW_CHECKED, CMD_FRAME, 32'd3000,
			result_t'{1'b0, BPM_MAX, 1'b0, 1'b1, 32'd0, 16'd0, 1'b0}));
		tab.push_back(mk_row(ROW_REQ, CMD_TAP, 32'd1400, '0));
		tab.push_back(mk_row(ROW_REQ, CMD_FRAME, 32'd1500, '0));
		tab.push_back(mk_row(ROW_REQ, CMD_FRAME, 32'd1600, '0));
		tab.push_back(mk_row(ROW_REQ, CMD_FRAME, 32'd1700, '0));
		tab.push_back(mk_row(ROW_REQ, CMD_FRAME, 32'd2150, '0));
		tab.push_back(mk_row(ROW_REQ, CMD_FRAME, 32'd1000, '0));
		tab.push_back(mk_cfg(CFG_WINDOW, 16'd2));
		tab.push_back(mk_row(ROW_REQ, CMD_TAP, 32'd1900, '0));
		tab.push_back(mk_row(ROW_REQ, CMD_TAP, 32'd5000, '0));
		tab.push_back(mk_cfg(CFG_TIMEOUT, 16'd0));
		tab.push_back(mk_row(ROW_REQ, CMD_TAP, 32'd5100, '0));
		tab.push_back(mk_row(ROW_REQ, CMD_TAP, 32'd5200, '0));
		tab.push_back(mk_cfg(CFG_TIMEOUT, 16'hFFFF));
		tab.push_back(mk_cfg(CFG_WINDOW, 16'd15));
		tab.push_back(mk_row(ROW_REQ, CMD_TAP, 32'hFFFF_FF00, '0));
		tab.push_back(mk_row(ROW_REQ, CMD_TAP, 32'h0000_0100, '0));
		tab.push_back(mk_row(ROW_REQ, CMD_FRAME, 32'hFFFF_FFFF, '0));
		tab.push_back(mk_row(ROW_REQ, CMD_FRAME, 32'h0000_0400, '0));
		tab.push_back(mk_row(ROW_REQ, CMD_TAP, 32'h0000_00F0, '0));
		tab.push_back(mk_cfg(CFG_WINDOW, 16'd0));
		tab.push_back(mk_cfg(CFG_WINDOW, 16'd1));
		tab.push_back(mk_row(ROW_REQ, CMD_TAP, 32'h0000_0400, '0));
		tab.push_back(mk_cfg(CFG_TIMEOUT, 16'd1));
		tab.push_back(mk_row(ROW_REQ, CMD_TAP, 32'h7FFF_FFFF, '0));
		tab.push_back(mk_row(ROW_REQ, CMD_TAP, 32'h8000_0000, '0));
		tab.push_back(mk_row(ROW_REQ, CMD_FRAME, 32'h8000_0000, '0));

		tx_idle = 1'b1;
		foreach (tab[i]) begin
			case (tab[i].kind)
				ROW_CFG:     write_reg(tab[i].idx, tab[i].data);
				ROW_CHECKED: send_req(tab[i].cmd, tab[i].t, 1'b1, tab[i].res);
				default:     send_req(tab[i].cmd, tab[i].t, 1'b0, '0);
			endcase
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			tail = (ph == PHASES - 1);
			case (ph)
				0: begin
					tmo = 16'hFFFF;
					win = 16'd8;
				end
				1: begin
					tmo = 16'd1;
					win = 16'd2;
				end
				2: begin
					tmo = 16'd0;
					win = 16'd15;
				end
				default: begin
					tmo = 16'($urandom_range(200, 6000));
					win = 16'($urandom_range(0, 15));
				end
			endcase
			write_reg(CFG_TIMEOUT, tmo);
			write_reg(CFG_WINDOW, win);
			if (tail) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end
			tnow = $urandom();
			if ($urandom_range(0, 3) == 0)
				tnow = 32'hFFFF_FFFF - $urandom_range(0, 20000);
			last_tap = tnow;
			phase_start = sent;
			while (sent - phase_start < PHASE_REQS) begin
				if (!tail)
					tx_idle = ($urandom_range(0, 2) != 0);
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					// steady tapping with jitter, frame ticks in between
					ival = $urandom_range(40, 1500);
					ntaps = $urandom_range(2, 10);
					repeat (ntaps) begin
						send_req(CMD_TAP, tnow, 1'b0, '0);
						last_tap = tnow;
						ft = tnow;
						repeat ($urandom_range(0, 4)) begin
							ft = ft + $urandom_range(1, ival / 2 + 1);
							send_req(CMD_FRAME, ft, 1'b0, '0);
						end
						tnow = tnow + ival + $urandom_range(0, 30) - 15;
					end
				end else if (pick < 76) begin
					send_req(CMD_TAP, tnow, 1'b0, '0);
					send_req(CMD_TAP, tnow, 1'b0, '0);
					send_req(CMD_FRAME, tnow + $urandom_range(0, 500), 1'b0, '0);
					last_tap = tnow;
				end else if (pick < 82) begin
					send_req(CMD_FRAME, last_tap - $urandom_range(1, 5000), 1'b0, '0);
				end else if (pick < 88) begin
					send_req(1'($urandom_range(0, 1)), $urandom(), 1'b0, '0);
				end else if (pick < 94) begin
					tnow = tnow + $urandom_range(1000, 70000);
					send_req(CMD_FRAME, tnow, 1'b0, '0);
				end else if (pick < 97) begin
					if (!tail)
						wait_drained();
				end else begin
					tnow = 32'hFFFF_FFFF - $urandom_range(0, 3000);
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
